@@ rtl/acm_pkg.sv @@
package acm_pkg;

  localparam int BlockW = 128;
  localparam int HalfW = 64;
  localparam int CountW = 5;
  localparam int ByteN = 16;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [7:0] ReduceByte = 8'h87;
  localparam logic [7:0] FieldPoly = 8'h1b;
  localparam logic [7:0] FirstRcon = 8'h01;
  localparam logic [3:0] LastRound = 4'd10;

  localparam logic [2047:0] SboxTable = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SboxTable[(11'd255 - {3'd0, x}) * 11'd8 +: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? FieldPoly : 8'h00);
  endfunction

  function automatic logic [BlockW-1:0] gf_double(input logic [BlockW-1:0] v);
    return {v[BlockW-2:0], 1'b0} ^ {{(BlockW-8){1'b0}}, (v[BlockW-1] ? ReduceByte : 8'h00)};
  endfunction

endpackage

@@ rtl/acm_prep.sv @@
module acm_prep (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [acm_pkg::BlockW-1:0]  blk,
  input  logic [acm_pkg::BlockW-1:0]  chain,
  input  logic [acm_pkg::BlockW-1:0]  mask,
  input  logic [acm_pkg::CountW-1:0]  cnt,
  output logic                        done,
  output logic [acm_pkg::BlockW-1:0]  data
);

  logic [acm_pkg::BlockW-1:0] blk_sr_r, chn_sr_r, msk_sr_r, out_sr_r;
  logic [3:0] idx_r;
  logic       busy_r, done_r;
  logic [7:0] msg_byte, x_byte;

  always_comb begin
    if ({1'b0, idx_r} < cnt) begin
      msg_byte = blk_sr_r[acm_pkg::BlockW-1 -: 8];
    end else if ({1'b0, idx_r} == cnt) begin
      msg_byte = acm_pkg::PadByte;
    end else begin
      msg_byte = 8'h00;
    end
    x_byte = msg_byte ^ chn_sr_r[acm_pkg::BlockW-1 -: 8] ^ msk_sr_r[acm_pkg::BlockW-1 -: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= busy_r && (idx_r == 4'd15);
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + 4'd1;
        if (idx_r == 4'd15) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      blk_sr_r <= blk;
      chn_sr_r <= chain;
      msk_sr_r <= mask;
    end else if (busy_r) begin
      blk_sr_r <= {blk_sr_r[acm_pkg::BlockW-9:0], 8'h00};
      chn_sr_r <= {chn_sr_r[acm_pkg::BlockW-9:0], 8'h00};
      msk_sr_r <= {msk_sr_r[acm_pkg::BlockW-9:0], 8'h00};
      out_sr_r <= {out_sr_r[acm_pkg::BlockW-9:0], x_byte};
    end
  end

  assign done = done_r;
  assign data = out_sr_r;

endmodule

@@ rtl/acm_aes.sv @@
module acm_aes (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [acm_pkg::BlockW-1:0]  pt,
  input  logic [acm_pkg::BlockW-1:0]  key,
  output logic                        busy,
  output logic                        done,
  output logic [acm_pkg::BlockW-1:0]  ct
);

  logic [acm_pkg::BlockW-1:0] st_r, rk_r, rk_nxt, sr, mc, st_nxt;
  logic [7:0] rc_r;
  logic [3:0] rnd_r;
  logic       busy_r, done_r;
  logic [7:0] a0, a1, a2, a3, all;
  logic [31:0] t;

  always_comb begin
    t = {acm_pkg::sbox(rk_r[23:16]) ^ rc_r, acm_pkg::sbox(rk_r[15:8]),
         acm_pkg::sbox(rk_r[7:0]), acm_pkg::sbox(rk_r[31:24])};
    rk_nxt[127:96] = rk_r[127:96] ^ t;
    rk_nxt[95:64]  = rk_r[95:64] ^ rk_nxt[127:96];
    rk_nxt[63:32]  = rk_r[63:32] ^ rk_nxt[95:64];
    rk_nxt[31:0]   = rk_r[31:0] ^ rk_nxt[63:32];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127 - 8 * (4 * c + r) -: 8] =
          acm_pkg::sbox(st_r[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
      end
    end
    mc = sr;
    for (int c = 0; c < 4; c++) begin
      a0 = sr[127 - 32 * c -: 8];
      a1 = sr[119 - 32 * c -: 8];
      a2 = sr[111 - 32 * c -: 8];
      a3 = sr[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      mc[127 - 32 * c -: 8] = a0 ^ all ^ acm_pkg::xtime(a0 ^ a1);
      mc[119 - 32 * c -: 8] = a1 ^ all ^ acm_pkg::xtime(a1 ^ a2);
      mc[111 - 32 * c -: 8] = a2 ^ all ^ acm_pkg::xtime(a2 ^ a3);
      mc[103 - 32 * c -: 8] = a3 ^ all ^ acm_pkg::xtime(a3 ^ a0);
    end
    st_nxt = ((rnd_r == acm_pkg::LastRound) ? sr : mc) ^ rk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
      rc_r   <= acm_pkg::FirstRcon;
    end else begin
      done_r <= busy_r && (rnd_r == acm_pkg::LastRound);
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= 4'd1;
        rc_r   <= acm_pkg::FirstRcon;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 4'd1;
        rc_r  <= acm_pkg::xtime(rc_r);
        if (rnd_r == acm_pkg::LastRound) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      st_r <= pt ^ key;
      rk_r <= key;
    end else if (busy_r) begin
      st_r <= st_nxt;
      rk_r <= rk_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign ct   = st_r;

endmodule

@@ rtl/aes_cmac_mac_engine_core.sv @@
// AES-CMAC engine with an AES-128 key held in two configuration registers.
// Each input item carries one 16-byte message block; tlast marks the final
// block of a message and only that item produces a result item, the MAC.
// The configuration channel writes key_high (index 0) or key_low (index 1)
// and is always ready; write it only while the block is idle.
// An item is taken only while the block is idle, so items are handled one
// at a time. A block first passes a byte-serial preparation stage (one byte
// per cycle) and then an iterative AES core (one round per cycle); the first
// block of a message is preceded by an AES pass deriving the subkey base.
// The MAC sits in an output register until the receiver takes it; while the
// receiver stalls, a following message can still be processed up to its last
// block, which then waits for the output register to empty.
// Reset clears the chaining value, the message flag, the key and all control.
module aes_cmac_mac_engine_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // block_high, block_low, byte_count, zero fill
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // mac_high, mac_low
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLgen = 3'd1;
  localparam logic [2:0] StPrep = 3'd2;
  localparam logic [2:0] StEnc  = 3'd3;
  localparam logic       KeyHighIdx = 1'b0;

  logic [2:0]   state_r, state_nxt;
  logic [127:0] blk_r, chain_r, l_r, key_r, out_r;
  logic [4:0]   cnt_r;
  logic         last_r, in_msg_r, out_valid_r;
  logic         in_acc;
  logic         aes_start, aes_busy, aes_done, prep_start, prep_done;
  logic         prep_kick_r, out_load;
  logic [127:0] aes_pt, aes_ct, prep_data, k1, k2, mask;
  logic [4:0]   eff_cnt;

  assign in_tready = (state_r == StIdle);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign k1 = acm_pkg::gf_double(l_r);
  assign k2 = acm_pkg::gf_double(k1);
  assign mask = !last_r ? '0 : ((eff_cnt == 5'd16) ? k1 : k2);
  assign eff_cnt = !last_r ? 5'd16 : ((cnt_r > 5'd16) ? 5'd16 : cnt_r);

  assign aes_start  = (in_acc && !in_msg_r) || prep_done;
  assign aes_pt     = prep_done ? prep_data : '0;
  assign prep_start = prep_kick_r;
  assign out_load   = (state_r == StEnc) && !aes_busy && last_r
                      && !(out_valid_r && !out_tready);

  acm_prep u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .start (prep_start),
    .blk   (blk_r),
    .chain (chain_r),
    .mask  (mask),
    .cnt   (eff_cnt),
    .done  (prep_done),
    .data  (prep_data)
  );

  acm_aes u_aes (
    .clk   (clk),
    .rst_n (rst_n),
    .start (aes_start),
    .pt    (aes_pt),
    .key   (key_r),
    .busy  (aes_busy),
    .done  (aes_done),
    .ct    (aes_ct)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      StIdle: if (in_acc) state_nxt = in_msg_r ? StPrep : StLgen;
      StLgen: if (aes_done) state_nxt = StPrep;
      StPrep: if (prep_done) state_nxt = StEnc;
      StEnc: begin
        if (!aes_busy && !aes_done || aes_done) begin
          if (!last_r) begin
            state_nxt = aes_busy ? StEnc : StIdle;
          end else if (!aes_busy && !(out_valid_r && !out_tready)) begin
            state_nxt = StIdle;
          end
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
      prep_kick_r <= 1'b0;
      chain_r     <= '0;
      key_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      prep_kick_r <= (in_acc && in_msg_r) || (state_r == StLgen && aes_done);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == KeyHighIdx) begin
          key_r[127:64] <= cfg_data;
        end else begin
          key_r[63:0] <= cfg_data;
        end
      end
      if (state_r == StLgen && aes_done) begin
        chain_r  <= '0;
        in_msg_r <= 1'b1;
      end
      if (state_r == StEnc && !aes_busy) begin
        if (!last_r) begin
          chain_r <= aes_ct;
        end else if (out_load) begin
          chain_r  <= '0;
          in_msg_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      blk_r  <= {in_tdata[63:0], in_tdata[127:64]};
      cnt_r  <= in_tdata[132:128];
      last_r <= in_tlast;
    end
    if (state_r == StLgen && aes_done) begin
      l_r <= aes_ct;
    end
    if (out_load) begin
      out_r <= aes_ct;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r[63:0], out_r[127:64]};
  assign out_tlast  = 1'b1;

`ifndef SYNTH
  a_rise_from_enc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == StEnc))
    else $error("result raised outside encryption");
  a_idle_core: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StIdle) |-> !aes_busy)
    else $error("cipher busy while idle");
  a_prep_start: assert property (@(posedge clk) disable iff (!rst_n)
    prep_done |-> (state_r == StPrep))
    else $error("preparation finished out of sequence");
`endif

endmodule
